/* rtl/core/cfr_pkg.sv */
`timescale 1ns / 1ps

package cfr_pkg;

	localparam int MAX_PAYLOAD = 64;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 7;
	localparam int IDX_W       = 6;
	localparam int RAM_DEPTH   = 2 * MAX_PAYLOAD;
	localparam int ADDR_W      = $clog2(RAM_DEPTH);
	localparam int JQ_DEPTH    = 2;
	localparam int JQ_PTR_W    = $clog2(JQ_DEPTH);
	localparam int JQ_CNT_W    = $clog2(JQ_DEPTH + 1);

	localparam logic [BYTE_W-1:0] START_BYTE = 8'h21;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_CMD   = 3'd1,
		PH_LEN   = 3'd2,
		PH_DATA  = 3'd3,
		PH_CHECK = 3'd4
	} cfr_phase_t;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_BAD_SUM  = 2'd1,
		ST_TOO_LONG = 2'd2
	} cfr_status_t;

	// one finished frame, handed from front to back
	typedef struct packed {
		cfr_status_t         status;
		logic [BYTE_W-1:0]   command;
		logic [LEN_W-1:0]    length;
		logic                bank;
	} cfr_job_t;

	typedef struct packed {
		logic     push;
		logic     alloc;
		cfr_job_t job;
	} cfr_front_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} cfr_wr_t;

endpackage

/* rtl/core/cfr_ram.sv */
`timescale 1ns / 1ps

module cfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/cfr_front.sv */
`timescale 1ns / 1ps

module cfr_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [cfr_pkg::BYTE_W-1:0]   rx_byte,
	input  logic                         fifo_full,
	input  logic [1:0]                   banks_busy,
	output logic                         full,
	output cfr_pkg::cfr_front_t          fo,
	output cfr_pkg::cfr_wr_t             wr
);

	cfr_pkg::cfr_phase_t             phase_q, phase_d;
	logic [cfr_pkg::BYTE_W-1:0]      cmd_q, cmd_d;
	logic [cfr_pkg::LEN_W-1:0]       len_q, len_d;
	logic [cfr_pkg::LEN_W-1:0]       taken_q, taken_d;
	logic [cfr_pkg::BYTE_W-1:0]      sum_q, sum_d;
	logic                            wbank_q, wbank_d;
	logic                            acc;
	logic [cfr_pkg::BYTE_W-1:0]      sum_next;
	logic [cfr_pkg::LEN_W-1:0]       taken_inc;
	logic                            too_long;

	// stall payload bytes while both buffer banks are still owned by the back end
	assign full = fifo_full ||
		((phase_q == cfr_pkg::PH_DATA) && (banks_busy == 2'd2));
	assign acc       = push && !full;
	assign sum_next  = sum_q + rx_byte;
	assign taken_inc = taken_q + 1'b1;
	assign too_long  = rx_byte > cfr_pkg::BYTE_W'(cfr_pkg::MAX_PAYLOAD);

	always_comb begin
		phase_d = phase_q;
		cmd_d   = cmd_q;
		len_d   = len_q;
		taken_d = taken_q;
		sum_d   = sum_q;
		wbank_d = wbank_q;
		if (acc) begin
			case (phase_q)
				cfr_pkg::PH_CMD: begin
					cmd_d   = rx_byte;
					sum_d   = sum_next;
					phase_d = cfr_pkg::PH_LEN;
				end
				cfr_pkg::PH_LEN: begin
					sum_d = sum_next;
					if (too_long) begin
						phase_d = cfr_pkg::PH_HUNT;
					end else begin
						len_d   = rx_byte[cfr_pkg::LEN_W-1:0];
						taken_d = '0;
						phase_d = (rx_byte == '0) ? cfr_pkg::PH_CHECK : cfr_pkg::PH_DATA;
					end
				end
				cfr_pkg::PH_DATA: begin
					sum_d   = sum_next;
					taken_d = taken_inc;
					if (taken_inc >= len_q) begin
						phase_d = cfr_pkg::PH_CHECK;
					end
				end
				cfr_pkg::PH_CHECK: begin
					sum_d   = sum_next;
					phase_d = cfr_pkg::PH_HUNT;
					if ((sum_next == '0) && (len_q != '0)) begin
						wbank_d = !wbank_q;
					end
				end
				default: begin
					if (rx_byte == cfr_pkg::START_BYTE) begin
						sum_d   = cfr_pkg::START_BYTE;
						cmd_d   = '0;
						len_d   = '0;
						taken_d = '0;
						phase_d = cfr_pkg::PH_CMD;
					end else begin
						phase_d = cfr_pkg::PH_HUNT;
					end
				end
			endcase
		end
	end

	always_comb begin
		fo             = '0;
		fo.job.command = cmd_q;
		fo.job.bank    = wbank_q;
		fo.job.status  = cfr_pkg::ST_GOOD;
		wr.we          = 1'b0;
		wr.addr        = {wbank_q, taken_q[cfr_pkg::IDX_W-1:0]};
		wr.data        = rx_byte;
		if (acc) begin
			case (phase_q)
				cfr_pkg::PH_LEN: begin
					if (too_long) begin
						fo.push       = 1'b1;
						fo.job.status = cfr_pkg::ST_TOO_LONG;
					end
				end
				cfr_pkg::PH_DATA: begin
					wr.we = 1'b1;
				end
				cfr_pkg::PH_CHECK: begin
					fo.push = 1'b1;
					if (sum_next != '0) begin
						fo.job.status = cfr_pkg::ST_BAD_SUM;
					end else begin
						fo.job.length = len_q;
						fo.alloc      = (len_q != '0);
					end
				end
				default: begin
					fo.push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= cfr_pkg::PH_HUNT;
			cmd_q   <= '0;
			len_q   <= '0;
			taken_q <= '0;
			sum_q   <= '0;
			wbank_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			len_q   <= len_d;
			taken_q <= taken_d;
			sum_q   <= sum_d;
			wbank_q <= wbank_d;
		end
	end

endmodule

/* rtl/core/cfr_job_fifo.sv */
`timescale 1ns / 1ps

module cfr_job_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cfr_pkg::cfr_job_t din,
	input  logic              pop,
	output cfr_pkg::cfr_job_t dout,
	output logic              empty,
	output logic              full
);

	cfr_pkg::cfr_job_t                 mem_q [cfr_pkg::JQ_DEPTH];
	logic [cfr_pkg::JQ_PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
	logic [cfr_pkg::JQ_CNT_W-1:0]      cnt_q;
	logic                              do_push, do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == cfr_pkg::JQ_CNT_W'(cfr_pkg::JQ_DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/cfr_back.sv */
`timescale 1ns / 1ps

module cfr_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fifo_empty,
	input  cfr_pkg::cfr_job_t             job,
	output logic                          fifo_pop,
	output logic                          rd_en,
	output logic [cfr_pkg::ADDR_W-1:0]    rd_addr,
	input  logic [cfr_pkg::BYTE_W-1:0]    rd_data,
	output logic                          bank_release,
	input  logic                          pop,
	output logic                          empty,
	output logic [1:0]                    status,
	output logic [cfr_pkg::BYTE_W-1:0]    command,
	output logic [cfr_pkg::LEN_W-1:0]     length,
	output logic [cfr_pkg::IDX_W-1:0]     index,
	output logic [cfr_pkg::BYTE_W-1:0]    data_byte,
	output logic                          last
);

	logic                          active_q;
	cfr_pkg::cfr_job_t             job_q;
	logic [cfr_pkg::IDX_W-1:0]     idx_q;

	logic                          v_s1;
	cfr_pkg::cfr_job_t             job_s1;
	logic [cfr_pkg::IDX_W-1:0]     idx_s1;
	logic                          last_s1;
	logic                          ram_s1;

	logic                          v_s2;
	cfr_pkg::cfr_job_t             job_s2;
	logic [cfr_pkg::IDX_W-1:0]     idx_s2;
	logic                          last_s2;
	logic [cfr_pkg::BYTE_W-1:0]    data_s2;

	logic                          pop_ok, adv, issue, is_payload, last_issue, load;

	assign pop_ok     = pop && v_s2;
	assign adv        = v_s1 && (!v_s2 || pop_ok);
	assign issue      = active_q && (!v_s1 || adv);
	assign is_payload = (job_q.status == cfr_pkg::ST_GOOD) && (job_q.length != '0);
	assign last_issue = !is_payload ||
		((cfr_pkg::LEN_W'(idx_q) + 1'b1) == job_q.length);
	assign load       = !active_q && !fifo_empty;

	assign fifo_pop     = load;
	assign rd_en        = issue && is_payload;
	assign rd_addr      = {job_q.bank, idx_q};
	assign bank_release = issue && last_issue && is_payload;

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
		end
		if (issue) begin
			job_s1  <= job_q;
			idx_s1  <= idx_q;
			last_s1 <= last_issue;
			ram_s1  <= is_payload;
		end
		if (adv) begin
			job_s2  <= job_s1;
			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
			data_s2 <= ram_s1 ? rd_data : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
		end else begin
			if (load) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (issue) begin
				active_q <= !last_issue;
				idx_q    <= idx_q + 1'b1;
			end
			if (issue) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				v_s2 <= 1'b1;
			end else if (pop_ok) begin
				v_s2 <= 1'b0;
			end
		end
	end

	assign empty     = !v_s2;
	assign status    = job_s2.status;
	assign command   = job_s2.command;
	assign length    = job_s2.length;
	assign index     = idx_s2;
	assign data_byte = data_s2;
	assign last      = last_s2;

endmodule

/* rtl/core/command_frame_receiver.sv */
`timescale 1ns / 1ps

// Command frame receiver.
// Input side is a queue push port: a word is taken on a rising edge with push
// high and full low. Bytes outside a frame are dropped until the start byte.
// A frame is start, command, length, payload and checksum; it is good when the
// modulo-256 sum of all its bytes is zero.
// Result side is a queue pop port: while empty is low the oldest result is on
// status/command/length/index/data_byte/last; pop high takes it.
// A good frame yields one result per payload byte (an empty frame yields one),
// last marking the final one. A bad checksum or a length over the maximum
// yields a single error result.
// Results of a frame follow its checksum (or oversized length) word through
// the frame queue and back end, then stream at one per cycle while pop is high.
// Input rate is one word per cycle; the front stalls only when the two-entry
// frame queue is full, or on payload bytes while both payload buffer banks are
// still being read out by the back end, which is what holds back a stalled
// receiver. Reset clears all control state and starts in the hunting phase;
// the payload buffer holds no meaningful data until written.
module command_frame_receiver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [cfr_pkg::BYTE_W-1:0]    rx_byte,
	output logic                          empty,
	input  logic                          pop,
	output logic [1:0]                    status,
	output logic [cfr_pkg::BYTE_W-1:0]    command,
	output logic [cfr_pkg::LEN_W-1:0]     length,
	output logic [cfr_pkg::IDX_W-1:0]     index,
	output logic [cfr_pkg::BYTE_W-1:0]    data_byte,
	output logic                          last
);

	cfr_pkg::cfr_front_t             fo;
	cfr_pkg::cfr_wr_t                wr;
	cfr_pkg::cfr_job_t               jq_dout;
	logic                            jq_empty, jq_full, jq_pop;
	logic                            rd_en;
	logic [cfr_pkg::ADDR_W-1:0]      rd_addr;
	logic [cfr_pkg::BYTE_W-1:0]      rd_data;
	logic                            bank_release;
	logic [1:0]                      busy_q;

	// parse bytes, fill the payload bank, hand finished frames to the queue
	cfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.rx_byte    (rx_byte),
		.fifo_full  (jq_full),
		.banks_busy (busy_q),
		.full       (full),
		.fo         (fo),
		.wr         (wr)
	);

	// two payload banks: front fills one while back drains the other
	cfr_ram #(
		.WIDTH (cfr_pkg::BYTE_W),
		.DEPTH (cfr_pkg::RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (wr.we),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	cfr_job_fifo u_jq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fo.push),
		.din    (fo.job),
		.pop    (jq_pop),
		.dout   (jq_dout),
		.empty  (jq_empty),
		.full   (jq_full)
	);

	cfr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_empty   (jq_empty),
		.job          (jq_dout),
		.fifo_pop     (jq_pop),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.bank_release (bank_release),
		.pop          (pop),
		.empty        (empty),
		.status       (status),
		.command      (command),
		.length       (length),
		.index        (index),
		.data_byte    (data_byte),
		.last         (last)
	);

	// count banks owned by frames not yet read out; banks are used in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
		end else begin
			if (fo.alloc && !bank_release) begin
				busy_q <= busy_q + 1'b1;
			end else if (bank_release && !fo.alloc) begin
				busy_q <= busy_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_busy_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q != 2'd3)
		else $error("payload bank count out of range");

	a_no_write_owned: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> (busy_q != 2'd2))
		else $error("payload write while both banks are owned");

	a_jq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fo.push |-> !jq_full)
		else $error("frame queue overflow");

	a_release_needs_owner: assert property (@(posedge clk) disable iff (!arst_n)
		bank_release |-> (busy_q != 2'd0))
		else $error("bank released with none owned");
`endif

endmodule

/* sim/tb_command_frame_receiver.sv */
`timescale 1ns / 1ps

module tb_command_frame_receiver;
	import cfr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;  // far beyond the slowest correct run
	localparam int HOLD_CYCLES  = 300;     // long receiver hold-off to fill the block
	localparam int DRAIN_CYCLES = 16;      // extra wait before the final check for missing results
	localparam int REPORT_LINES = 30;

	// one expected result word, one field per output port
	typedef struct {
		cfr_status_t        status;
		logic [BYTE_W-1:0]  command;
		logic [LEN_W-1:0]   length;
		logic [IDX_W-1:0]   index;
		logic [BYTE_W-1:0]  data_byte;
		logic               last;
	} frame_result_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic [BYTE_W-1:0]  rx_byte = '0;
	logic               pop = 1'b0;
	logic               full;
	logic               empty;
	logic [1:0]         status;
	logic [BYTE_W-1:0]  command;
	logic [LEN_W-1:0]   length;
	logic [IDX_W-1:0]   index;
	logic [BYTE_W-1:0]  data_byte;
	logic               last;

	// bytes waiting to be offered, and results the frame tracker has predicted
	logic [BYTE_W-1:0]  pending_bytes[$];
	frame_result_t      awaited_results[$];

	// frame tracker state, owned by the driver process
	cfr_phase_t         trk_phase = PH_HUNT;
	logic [BYTE_W-1:0]  trk_cmd = '0;
	logic [LEN_W-1:0]   trk_len = '0;
	logic [LEN_W-1:0]   trk_taken = '0;
	logic [BYTE_W-1:0]  trk_sum = '0;
	logic [BYTE_W-1:0]  trk_payload[MAX_PAYLOAD];

	// traffic shaping, set by the stimulus process between phases
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	bit hold_armed = 1'b0;
	int hold_left = 0;

	int cycle_count = 0;
	int mismatch_count = 0;
	int bytes_queued = 0;
	int bytes_taken_in = 0;
	int results_checked = 0;
	int frames_good = 0;
	int frames_bad_sum = 0;
	int frames_too_long = 0;
	int full_stall_cycles = 0;

	command_frame_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.rx_byte   (rx_byte),
		.empty     (empty),
		.pop       (pop),
		.status    (status),
		.command   (command),
		.length    (length),
		.index     (index),
		.data_byte (data_byte),
		.last      (last)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Print one line per mismatch (up to a cap) and count every one.
	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_LINES)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
	                           input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h want %0h (result %0d)",
			                          name, got, want, results_checked));
	endtask

	function automatic void await_result(input cfr_status_t st, input logic [LEN_W-1:0] len,
	                                     input logic [IDX_W-1:0] idx,
	                                     input logic [BYTE_W-1:0] data, input logic fin);
		frame_result_t r;
		r.status    = st;
		r.command   = trk_cmd;
		r.length    = len;
		r.index     = idx;
		r.data_byte = data;
		r.last      = fin;
		awaited_results.push_back(r);
	endfunction

	// Advance the frame tracker by one accepted word and queue what it emits.
	task automatic track_frame_byte(input logic [BYTE_W-1:0] b);
		int i;
		case (trk_phase)
			PH_CMD: begin
				trk_cmd = b;
				trk_sum += b;
				trk_phase = PH_LEN;
			end
			PH_LEN: begin
				trk_sum += b;
				if (b > MAX_PAYLOAD) begin
					// oversized: error now, rest of the frame is line noise
					await_result(ST_TOO_LONG, '0, '0, '0, 1'b1);
					frames_too_long++;
					trk_phase = PH_HUNT;
				end else begin
					trk_len = b[LEN_W-1:0];
					trk_taken = '0;
					trk_phase = (b == 0) ? PH_CHECK : PH_DATA;
				end
			end
			PH_DATA: begin
				trk_payload[trk_taken[IDX_W-1:0]] = b;
				trk_sum += b;
				trk_taken++;
				if (trk_taken >= trk_len)
					trk_phase = PH_CHECK;
			end
			PH_CHECK: begin
				trk_sum += b;
				if (trk_sum != 0) begin
					await_result(ST_BAD_SUM, '0, '0, '0, 1'b1);
					frames_bad_sum++;
				end else if (trk_len == 0) begin
					await_result(ST_GOOD, '0, '0, '0, 1'b1);
					frames_good++;
				end else begin
					for (i = 0; i < trk_len; i++)
						await_result(ST_GOOD, trk_len, i[IDX_W-1:0], trk_payload[i],
						             i == trk_len - 1);
					frames_good++;
				end
				trk_phase = PH_HUNT;
			end
			default: begin
				// hunting: only the start byte opens a frame
				if (b == START_BYTE) begin
					trk_sum = START_BYTE;
					trk_cmd = '0;
					trk_len = '0;
					trk_taken = '0;
					trk_phase = PH_CMD;
				end else begin
					trk_phase = PH_HUNT;
				end
			end
		endcase
	endtask

	task automatic queue_byte(input logic [BYTE_W-1:0] b);
		pending_bytes.push_back(b);
		bytes_queued++;
	endtask

	// Queue one frame. A negative fill means random payload; spoil breaks the
	// checksum; an oversized length stops after the length byte.
	task automatic queue_frame(input logic [BYTE_W-1:0] cmd, input int len,
	                           input int fill, input bit spoil);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] b;
		int i;
		sum = START_BYTE + cmd + len[BYTE_W-1:0];
		queue_byte(START_BYTE);
		queue_byte(cmd);
		queue_byte(len[BYTE_W-1:0]);
		if (len > MAX_PAYLOAD)
			return;
		for (i = 0; i < len; i++) begin
			b = (fill < 0) ? BYTE_W'($urandom_range(0, 255)) : fill[BYTE_W-1:0];
			sum += b;
			queue_byte(b);
		end
		b = -sum;
		if (spoil)
			b += BYTE_W'($urandom_range(1, 255));
		queue_byte(b);
	endtask

	// Hold at the negative edge until every word is taken and every result seen.
	task automatic wait_until_idle;
		while (pending_bytes.size() != 0 || push || awaited_results.size() != 0)
			@(negedge clk);
	endtask

	// Mostly well-formed frames with random content, the rest broken frames
	// and noise. Keep payloads short; only now and then go near the maximum.
	task automatic queue_random_traffic(input int budget);
		int start;
		int r;
		int len;
		int i;
		start = bytes_queued;
		while (bytes_queued - start < budget) begin
			r = $urandom_range(0, 99);
			len = ($urandom_range(0, 99) < 6) ? $urandom_range(40, MAX_PAYLOAD)
			                                  : $urandom_range(0, 8);
			if (r < 70) begin
				queue_frame(BYTE_W'($urandom_range(0, 255)), len, -1, 1'b0);
			end else if (r < 80) begin
				queue_frame(BYTE_W'($urandom_range(0, 255)), len, -1, 1'b1);
			end else if (r < 88) begin
				queue_frame(BYTE_W'($urandom_range(0, 255)),
				            $urandom_range(MAX_PAYLOAD + 1, 255), -1, 1'b0);
				for (i = $urandom_range(0, 3); i > 0; i--)
					queue_byte(BYTE_W'($urandom_range(0, 255)));
			end else begin
				for (i = $urandom_range(1, 3); i > 0; i--)
					queue_byte(BYTE_W'($urandom_range(0, 255)));
			end
		end
	endtask

	// Driver: track the word taken at this edge, then hold it while full,
	// offer the next one, or idle.
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				track_frame_byte(rx_byte);
				bytes_taken_in++;
			end
			if (push && full) begin
				full_stall_cycles++;
			end else if (pending_bytes.size() != 0 &&
			             $urandom_range(0, 99) >= send_idle_pct) begin
				push <= 1'b1;
				rx_byte <= pending_bytes.pop_front();
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Receiver hold-off: arm once on request and count the stretch down.
	always @(posedge clk) begin
		if (hold_request && !hold_armed) begin
			hold_armed <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: check the result word taken at this edge against the oldest
	// expectation, then decide whether to pop next cycle.
	always @(posedge clk) begin
		frame_result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result status %0d command %0h",
					                          status, command));
				end else begin
					want = awaited_results.pop_front();
					check_field("status", status, want.status);
					check_field("command", command, want.command);
					check_field("length", length, want.length);
					check_field("index", index, want.index);
					check_field("data_byte", data_byte, want.data_byte);
					check_field("last", last, want.last);
				end
				results_checked++;
			end
			pop <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still awaited",
			         cycle_count, awaited_results.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: stray bytes, start byte as command and as payload, payload
		// extremes, empty frame, oversized length with trailing noise, bad sum.
		queue_byte(8'h00);
		queue_byte(8'hFF);
		queue_byte(8'h22);
		queue_frame(START_BYTE, 0, -1, 1'b0);
		queue_frame(8'hFF, 2, 8'hFF, 1'b0);
		queue_frame(8'h00, 1, START_BYTE, 1'b0);
		queue_frame(8'hA5, 255, -1, 1'b0);
		queue_byte(8'h20);
		queue_frame(8'h5A, 0, -1, 1'b1);
		wait_until_idle();

		// Random phases: no idling (with one maximum-length frame), sender
		// idle, receiver stalling, both idling lightly.
		queue_frame(BYTE_W'($urandom_range(0, 255)), MAX_PAYLOAD, -1, 1'b0);
		queue_random_traffic(20);
		wait_until_idle();
		send_idle_pct = 54;
		queue_random_traffic(20);
		wait_until_idle();
		send_idle_pct = 0;
		recv_stall_pct = 54;
		queue_random_traffic(20);
		wait_until_idle();
		send_idle_pct = 10;
		recv_stall_pct = 10;
		queue_random_traffic(20);
		wait_until_idle();

		// Pressure: hold the receiver off while short frames keep coming, so
		// the frame queue fills and full stalls the sender.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b1;
		repeat (8)
			queue_frame(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3), -1, 1'b0);
		wait_until_idle();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (awaited_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

		$display("Covered %0d words in, %0d results: %0d good, %0d bad-sum, %0d oversized",
		         bytes_taken_in, results_checked, frames_good, frames_bad_sum,
		         frames_too_long);
		$display("Sender held by full for %0d cycles; %0d mismatches", full_stall_cycles,
		         mismatch_count);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
